### hw/rtl/prime_count_trial_division_assert.svh
// Assertion macros shared by the trial-division primality tester RTL.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef PRIME_COUNT_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_COUNT_TRIAL_DIVISION_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: prop is a property expression such as a |-> b.
`define PCTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Next-cycle implication: cond in one cycle implies chk in the next.
`define PCTD_ASSERT_NEXT(lbl, cond, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (chk)) \
    else $error(msg);
`else
`define PCTD_ASSERT(lbl, prop, msg)
`define PCTD_ASSERT_NEXT(lbl, cond, chk, msg)
`endif

`endif

### hw/rtl/pctd_pkg.sv
`timescale 1ns / 1ps
// Package for the trial-division primality tester: default widths,
// sequencer state type and the remainder unit status struct. No dependencies.
package pctd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 15;
  localparam int unsigned COUNT_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } pctd_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } pctd_rem_status_t;

endpackage

### hw/rtl/prime_count_trial_division.sv
`timescale 1ns / 1ps
// Values below 2 and even values are settled on acceptance; other values try odd divisors
// 3, 5, ... while d*d <= value, each through the remainder unit, until one divides the value.
// Throughput: one request at a time; each trial divisor goes through the shared
// bit-serial remainder unit. A finished result waits in an output register, so the
// next request is taken while it is pending.
// Reset (rst_ni low, async): sequencer idle, output empty, block prime count cleared.
`include "prime_count_trial_division_assert.svh"

module prime_count_trial_division import pctd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  block_end_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_prime_flag_o,
  output logic [COUNT_BITS-1:0] primes_so_far_o,
  output logic                  block_done_o
);

  // Running square of the divisor; it overshoots the value by at most one step.
  localparam int unsigned SqW = VALUE_BITS + 3;

  pctd_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [SqW-1:0]        sq_q, sq_d;
  logic                  prime_q, prime_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic                  flag_q, flag_d;
  logic [COUNT_BITS-1:0] so_far_q, so_far_d;
  logic                  bdone_q, bdone_d;

  logic                  in_fire;
  logic                  load;
  logic                  rem_start;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [SqW-1:0]        value_ext;
  pctd_rem_status_t      rem_st;

  // Shared remainder unit: value mod current divisor, one bit per cycle.
  pctd_rem #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (value_q),
    .divisor_i  (div_q),
    .status_o   (rem_st)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign value_ext  = {3'b000, value_q};

  // Saturating count including the value just decided.
  assign cnt_inc = (prime_q && (cnt_q != '1)) ? cnt_q + COUNT_BITS'(1) : cnt_q;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    last_d      = last_q;
    div_d       = div_q;
    sq_d        = sq_q;
    prime_d     = prime_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    flag_d      = flag_q;
    so_far_d    = so_far_q;
    bdone_d     = bdone_q;
    rem_start   = 1'b0;
    load        = 1'b0;

    // Drop the pending result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          value_d = value_i;
          last_d  = block_end_i;
          div_d   = VALUE_BITS'(3);
          sq_d    = SqW'(9);
          // Settle the trivial cases here: below two, two itself, other evens.
          if (value_i == VALUE_BITS'(2)) begin
            prime_d = 1'b1;
            state_d = ST_DONE;
          end else if ((value_i < VALUE_BITS'(2)) || !value_i[0]) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // Out of candidates once the divisor squared exceeds the value.
        if (sq_q > value_ext) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.rem_zero) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
            div_d   = div_q + VALUE_BITS'(2);
            sq_d    = sq_q + {1'b0, div_q, 2'b00} + SqW'(4);
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        // Hold until the output register is free, then post the result.
        if (!out_valid_q || out_ready_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          flag_d      = prime_q;
          so_far_d    = cnt_inc;
          bdone_d     = last_q;
          cnt_d       = last_q ? '0 : cnt_inc;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    last_q   <= last_d;
    div_q    <= div_d;
    sq_q     <= sq_d;
    prime_q  <= prime_d;
    flag_q   <= flag_d;
    so_far_q <= so_far_d;
    bdone_q  <= bdone_d;
  end

  assign out_valid_o     = out_valid_q;
  assign is_prime_flag_o = flag_q;
  assign primes_so_far_o = so_far_q;
  assign block_done_o    = bdone_q;

  `PCTD_ASSERT(a_div_within_bound, (state_q == ST_DIV) |-> (sq_q <= value_ext), "past bound")
  `PCTD_ASSERT(a_odd_trial, (state_q == ST_CHECK) |-> (value_q[0] && div_q[0]), "even trial")
  `PCTD_ASSERT_NEXT(a_block_clear, load && last_q, cnt_q == '0, "count not cleared at block end")

endmodule

### hw/rtl/pctd_rem.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on pctd_pkg and prime_count_trial_division_assert.svh.
`include "prime_count_trial_division_assert.svh"

module pctd_rem import pctd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output pctd_rem_status_t      status_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] shift_q, shift_d;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, shift_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(VALUE_BITS);
      rem_d   = '0;
      shift_d = dividend_i;
    end else if (busy_q) begin
      rem_d   = (trial >= {1'b0, divisor_i}) ? diff[VALUE_BITS-1:0]
                                             : trial[VALUE_BITS-1:0];
      shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

  `PCTD_ASSERT(a_rem_no_restart, start_i |-> !busy_q, "remainder unit restarted while busy")
  `PCTD_ASSERT(a_rem_done_after_busy, done_q |-> $past(busy_q), "done without a preceding step")

endmodule

### verif/prime_count_trial_division_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for prime_count_trial_division: directed, block-restart,
// back-pressure and random tests, all scored against an in-bench trial-division predictor.
// Depends on pctd_pkg and the prime_count_trial_division RTL only.
module prime_count_trial_division_tb import pctd_pkg::*; ();

  localparam int unsigned VAL_W = VALUE_BITS_DEF;
  localparam int unsigned CNT_W = COUNT_BITS_DEF;
  localparam int unsigned VAL_MAX = (1 << VAL_W) - 1;
  // One block of tiny primes, then a fresh block to show the count restarts.
  localparam int unsigned BLOCK_RUN = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  // Allow several times the slowest single result and the hold-off.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned RANDOM_SEGMENTS = 4;

  typedef struct packed {
    logic             prime;
    logic [CNT_W-1:0] count;
    logic             done;
  } prime_result_t;

  // Value families used by the random test.
  typedef enum int unsigned {
    VC_ANY,
    VC_SMALL,
    VC_HIGH_ODD,
    VC_SQUARE,
    VC_EDGE
  } value_class_e;

  // Clock and reset; every DUT input is known from time zero.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic [VAL_W-1:0] value = '0;
  logic             block_end = 1'b0;
  logic             out_ready = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic             is_prime_flag;
  logic [CNT_W-1:0] primes_so_far;
  logic             block_done;

  // Predictor state and the store of results still owed by the block.
  logic [CNT_W-1:0] block_count_model = '0;
  prime_result_t    owed_results[$];

  // Sender / receiver idling controls.
  bit               tx_gaps_en = 1'b0;
  int unsigned      burst_left = 0;
  bit               rx_stall_en = 1'b0;
  int unsigned      hold_req = 0;
  int unsigned      hold_left = 0;
  logic [15:0]      stall_pattern = '1;
  logic [3:0]       stall_phase = '0;

  // Bookkeeping for the summary and the verdict.
  int unsigned      n_errors = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_checked = 0;
  int unsigned      n_primes = 0;
  int unsigned      n_blocks = 0;
  int unsigned      idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  prime_count_trial_division #(
    .VALUE_BITS(VAL_W),
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_i        (value),
    .block_end_i    (block_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .is_prime_flag_o(is_prime_flag),
    .primes_so_far_o(primes_so_far),
    .block_done_o   (block_done)
  );

  // Decide primality the slow, obvious way: odd divisors from 3 while d*d <= n.
  function automatic logic trial_division_prime(input logic [VAL_W-1:0] v);
    int unsigned n;
    int unsigned d;
    n = v;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the per-block prime count for one request and return the result it owes.
  function automatic prime_result_t next_prime_count(input logic [VAL_W-1:0] v,
                                                     input logic last);
    prime_result_t r;
    r.prime = trial_division_prime(v);
    // Saturate: once the count is full it holds until the block closes.
    if (r.prime && block_count_model != '1) block_count_model = block_count_model + CNT_W'(1);
    r.count = block_count_model;
    r.done = last;
    // The closing result still shows this block's count; clear afterwards.
    if (last) block_count_model = '0;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    value_class_e cls;
    int unsigned  pick;
    int unsigned  root;
    logic [VAL_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 35) cls = VC_ANY;
    else if (pick < 55) cls = VC_SMALL;
    else if (pick < 75) cls = VC_HIGH_ODD;
    else if (pick < 88) cls = VC_SQUARE;
    else cls = VC_EDGE;
    case (cls)
      VC_ANY: v = VAL_W'($urandom_range(0, VAL_MAX));
      VC_SMALL: v = VAL_W'($urandom_range(0, 63));
      // Near the top, odd: the long trial loops and the largest primes live here.
      VC_HIGH_ODD: v = VAL_W'((VAL_MAX - $urandom_range(0, 4095)) | 1);
      // Odd squares land exactly on the d*d == value boundary.
      VC_SQUARE: begin
        root = 2 * $urandom_range(1, 90) + 1;
        v = VAL_W'(root * root);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = VAL_W'(0);
          1: v = VAL_W'(1);
          2: v = VAL_W'(2);
          3: v = VAL_W'(3);
          4: v = VAL_W'(VAL_MAX - 1);
          default: v = VAL_W'(VAL_MAX);
        endcase
      end
    endcase
    return v;
  endfunction

  // Send one request. Hold valid and payload until the handshake, then record
  // the expected result. With gaps enabled, drop valid between random bursts.
  task automatic push_request(input logic [VAL_W-1:0] v, input logic last);
    int unsigned gap;
    if (tx_gaps_en && burst_left == 0) begin
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    value <= v;
    block_end <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    owed_results.push_back(next_prime_count(v, last));
    n_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  // Drop valid and wait until every owed result has been scored.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, zero/one/two, the first odd primes, odd squares on the trial
  // bound, the largest 15-bit prime and single-item blocks.
  task automatic test_directed();
    int unsigned dir_vals [20] = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 121, 16384,
                                   32766, 32767, 32749, 32761, 2, 1, 7, 3};
    logic [19:0] dir_last = 20'hB8004;
    int unsigned i;
    tx_gaps_en = 1'b1;
    rx_stall_en = 1'b1;
    for (i = 0; i < 20; i++) push_request(VAL_W'(dir_vals[i]), dir_last[i]);
    wait_drained();
  endtask

  // Run one block of tiny primes, then show that the next block starts again
  // from zero. Idle nothing, to keep it quick.
  task automatic test_block_restart();
    int unsigned i;
    logic [VAL_W-1:0] v;
    tx_gaps_en = 1'b0;
    rx_stall_en = 1'b0;
    for (i = 0; i < BLOCK_RUN; i++) begin
      case ($urandom_range(0, 3))
        0: v = VAL_W'(2);
        1: v = VAL_W'(3);
        2: v = VAL_W'(5);
        default: v = VAL_W'(7);
      endcase
      push_request(v, i == BLOCK_RUN - 1);
    end
    push_request('0, 1'b0);
    push_request(VAL_W'(3), 1'b1);
    wait_drained();
  endtask

  // Hold the result channel off for a long stretch while requests keep coming,
  // so the output register and the sequencer fill and input ready drops.
  task automatic test_backpressure();
    int unsigned i;
    tx_gaps_en = 1'b0;
    rx_stall_en = 1'b0;
    hold_req = HOLD_OFF_CYCLES;
    for (i = 0; i < 8; i++) begin
      push_request(VAL_W'($urandom_range(0, 63)), $urandom_range(0, 3) == 0);
    end
    wait_drained();
  endtask

  // Random values in four segments that cycle through the idling combinations,
  // including one stretch with no gaps and no stalls at all.
  task automatic test_random();
    int unsigned seg;
    int unsigned i;
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      tx_gaps_en = (seg == 0) || (seg == 2);
      rx_stall_en = (seg == 0) || (seg == 3);
      for (i = 0; i < RANDOM_ITEMS / RANDOM_SEGMENTS; i++) begin
        push_request(random_value(), $urandom_range(0, 7) == 0);
      end
    end
    wait_drained();
  endtask

  // Result side: a requested hold-off wins, then the rotating stall pattern,
  // else stay ready. The pattern refreshes each time its phase wraps and is biased ready.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (!rx_stall_en) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_phase == 0) stall_pattern = 16'($urandom() | $urandom());
      out_ready <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 4'd1;
    end
  end

  // Score every accepted result against the oldest owed one, field by field.
  always @(posedge clk_i) begin
    prime_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: is_prime_flag=%0b primes_so_far=%0d block_done=%0b",
               is_prime_flag, primes_so_far, block_done);
        n_errors++;
      end else begin
        want = owed_results.pop_front();
        if (is_prime_flag !== want.prime) begin
          $error("is_prime_flag: expected %0b, actual %0b", want.prime, is_prime_flag);
          n_errors++;
        end
        if (primes_so_far !== want.count) begin
          $error("primes_so_far: expected %0d, actual %0d", want.count, primes_so_far);
          n_errors++;
        end
        if (block_done !== want.done) begin
          $error("block_done: expected %0b, actual %0b", want.done, block_done);
          n_errors++;
        end
        n_checked++;
        if (want.prime) n_primes++;
        if (want.done) n_blocks++;
      end
    end
  end

  // Watchdog: end the run if no handshake happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still owed",
               idle_cycles, owed_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_restart();
    test_backpressure();
    test_random();
    // Every request owes exactly one result; a short tail catches stray extras.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Scored %0d results for %0d requests: %0d prime, %0d blocks closed.",
             n_checked, n_sent, n_primes, n_blocks);
    $display("Mix: directed corners, full-range/small/near-top/odd-square randoms, %0d-cycle hold.",
             HOLD_OFF_CYCLES);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_rem.sv
hw/rtl/prime_count_trial_division.sv
verif/prime_count_trial_division_tb.sv
